[sv/mma_pkg.sv]
// ----------------------------------------------------------------------------
// mma_pkg: shared types and constants for the matrix multiply-accumulate core
// Field widths, saturation bounds and the tag that follows each MAC step.
// ----------------------------------------------------------------------------
package mma_pkg;

    localparam int IDX_W  = 6;   // row / column index width on the ports
    localparam int DIM_W  = 7;   // matrix dimension width (1..64)
    localparam int VAL_W  = 16;  // A and B elements, signed Q1.14
    localparam int PROD_W = 32;  // product of two Q1.14 values, Q3.28
    localparam int ACC_W  = 48;  // C elements, 28 fraction bits

    localparam logic signed [ACC_W-1:0] SAT_HI = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_LO = {1'b1, {(ACC_W-1){1'b0}}};

    // One multiply-accumulate step on its way through the MAC pipeline
    typedef struct packed {
        logic             valid;
        logic             first;     // k == 0: start from C0
        logic             last_k;    // k == n-1: column complete
        logic [IDX_W-1:0] col;
        logic             last_col;  // j == n-1
    } mma_tag_t;

endpackage

[sv/mma_store.sv]
// ----------------------------------------------------------------------------
// mma_store: element storage for matrices A, B and C0
// One write port fed by load transfers, one registered read port per matrix.
// ----------------------------------------------------------------------------
module mma_store
    import mma_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [IDX_W-1:0]         wr_row,
    input  logic [IDX_W-1:0]         wr_col,
    input  logic signed [VAL_W-1:0]  wr_a,
    input  logic signed [VAL_W-1:0]  wr_b,
    input  logic signed [ACC_W-1:0]  wr_c,
    input  logic                     rd_en,
    input  logic [IDX_W-1:0]         rd_row,
    input  logic [IDX_W-1:0]         rd_k,
    input  logic [IDX_W-1:0]         rd_j,
    output logic signed [VAL_W-1:0]  a_q,
    output logic signed [VAL_W-1:0]  b_q,
    output logic signed [ACC_W-1:0]  c_q
);

    localparam int AIDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int ADDR_W = 2 * AIDX_W;
    localparam int DEPTH  = 1 << ADDR_W;

    logic signed [VAL_W-1:0] mem_a [DEPTH];
    logic signed [VAL_W-1:0] mem_b [DEPTH];
    logic signed [ACC_W-1:0] mem_c [DEPTH];

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] a_addr;
    logic [ADDR_W-1:0] b_addr;
    logic [ADDR_W-1:0] c_addr;

    assign wr_addr = {AIDX_W'(wr_row), AIDX_W'(wr_col)};
    assign a_addr  = {AIDX_W'(rd_row), AIDX_W'(rd_k)};
    assign b_addr  = {AIDX_W'(rd_k),   AIDX_W'(rd_j)};
    assign c_addr  = {AIDX_W'(rd_row), AIDX_W'(rd_j)};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_a[wr_addr] <= wr_a;
            mem_b[wr_addr] <= wr_b;
            mem_c[wr_addr] <= wr_c;
        end
        // hold read data while the pipeline is stalled
        if (rd_en) begin
            a_q <= mem_a[a_addr];
            b_q <= mem_b[b_addr];
            c_q <= mem_c[c_addr];
        end
    end

endmodule

[sv/mma_mac.sv]
// ----------------------------------------------------------------------------
// mma_mac: shared multiply-accumulate unit
// Multiplies one A and one B element per cycle unless stalled, adds into a saturating
// 48-bit accumulator and hands each finished C element to the output register.
// ----------------------------------------------------------------------------
module mma_mac
    import mma_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  mma_tag_t                 tag_in,
    input  logic signed [VAL_W-1:0]  a_q,
    input  logic signed [VAL_W-1:0]  b_q,
    input  logic signed [ACC_W-1:0]  c_q,
    input  logic                     m_tready,
    output logic                     m_tvalid,
    output logic signed [ACC_W-1:0]  m_result,
    output logic [IDX_W-1:0]         m_col,
    output logic                     m_last,
    output logic                     stall,
    output logic                     pipe_busy
);

    mma_tag_t                 tag1_reg, tag1_next;
    mma_tag_t                 tag2_reg, tag2_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  c2_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_base;
    logic signed [ACC_W:0]    sum_wide;
    logic signed [ACC_W-1:0]  sum_sat;
    logic                     emit;
    logic                     out_valid_reg, out_valid_next;
    logic signed [ACC_W-1:0]  out_data_reg;
    logic [IDX_W-1:0]         out_col_reg;
    logic                     out_last_reg;

    assign stall     = out_valid_reg & ~m_tready;
    assign pipe_busy = tag1_reg.valid | tag2_reg.valid;

    assign acc_base = tag2_reg.first ? c2_reg : acc_reg;
    assign sum_wide = {acc_base[ACC_W-1], acc_base} + (ACC_W+1)'(prod_reg);

    always_comb begin
        if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
            sum_sat = sum_wide[ACC_W] ? SAT_LO : SAT_HI;
        end else begin
            sum_sat = sum_wide[ACC_W-1:0];
        end
    end

    assign emit = tag2_reg.valid & tag2_reg.last_k & ~stall;

    always_comb begin
        tag1_next = stall ? tag1_reg : tag_in;
        tag2_next = stall ? tag2_reg : tag1_reg;
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg      <= '0;
            tag2_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            tag1_reg      <= tag1_next;
            tag2_reg      <= tag2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            prod_reg <= a_q * b_q;
            c2_reg   <= c_q;
            if (tag2_reg.valid) begin
                acc_reg <= sum_sat;
            end
        end
        if (emit) begin
            out_data_reg <= sum_sat;
            out_col_reg  <= tag2_reg.col;
            out_last_reg <= tag2_reg.last_col;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = out_data_reg;
    assign m_col    = out_col_reg;
    assign m_last   = out_last_reg;

    a_acc_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> $stable(acc_reg))
        else $error("accumulator moved during a stall");

    a_emit_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_tvalid)
        else $error("finished column did not reach the output register");

    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        (!stall && !(tag2_reg.valid && tag2_reg.last_k)) |=> !m_tvalid)
        else $error("output valid without a finished column");

endmodule

[sv/mma_seq.sv]
// ----------------------------------------------------------------------------
// mma_seq: row sequencer
// Accepts input transfers, issues store writes for loads and walks column j
// and index k of a requested row, one MAC step per cycle unless stalled.
// ----------------------------------------------------------------------------
module mma_seq
    import mma_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              in_func,
    input  logic [IDX_W-1:0]  in_row,
    input  logic [IDX_W-1:0]  in_col,
    input  logic [DIM_W-1:0]  dim,
    input  logic              stall,
    input  logic              pipe_busy,
    output logic              wr_en,
    output logic [IDX_W-1:0]  rd_row,
    output logic [IDX_W-1:0]  rd_k,
    output logic [IDX_W-1:0]  rd_j,
    output mma_tag_t          tag_out
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [DIM_W-1:0] n_reg, n_next;
    logic             accept;
    logic             row_ok;
    logic             col_ok;
    logic             issue;
    logic             k_end;
    logic             j_end;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign row_ok   = {1'b0, in_row} < dim;
    assign col_ok   = {1'b0, in_col} < dim;
    assign wr_en    = accept & ~in_func & row_ok & col_ok;

    assign issue = (state_reg == ST_RUN) & ~stall;
    assign k_end = ({1'b0, k_reg} == n_reg - DIM_W'(1));
    assign j_end = ({1'b0, j_reg} == n_reg - DIM_W'(1));

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        n_next     = n_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && in_func && row_ok) begin
                    state_next = ST_RUN;
                    row_next   = in_row;
                    n_next     = dim;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            ST_RUN: begin
                if (issue) begin
                    if (k_end) begin
                        k_next = '0;
                        j_next = j_reg + IDX_W'(1);
                        if (j_end) begin
                            state_next = ST_DRAIN;
                        end
                    end else begin
                        k_next = k_reg + IDX_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
                // wait for the last column to leave the MAC pipeline
                if (!pipe_busy && !stall) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_reg <= row_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        n_reg   <= n_next;
    end

    assign rd_row = row_reg;
    assign rd_k   = k_reg;
    assign rd_j   = j_reg;

    always_comb begin
        tag_out.valid    = issue;
        tag_out.first    = (k_reg == '0);
        tag_out.last_k   = k_end;
        tag_out.col      = j_reg;
        tag_out.last_col = j_end;
    end

    a_issue_unstalled: assert property (@(posedge aclk) disable iff (!aresetn)
        tag_out.valid |-> !stall)
        else $error("MAC step issued during a stall");

    a_final_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (tag_out.valid && tag_out.last_k && tag_out.last_col) |=> state_reg == ST_DRAIN)
        else $error("row walk did not end after its final step");

    a_drain_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN && !pipe_busy && !stall) |=> s_tready)
        else $error("sequencer stuck after drain");

endmodule

[sv/matrix_multiply_accumulate_core.sv]
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_core: C = C0 + A*B, one row of C per request
// Top level: configuration register, field unpacking, store, sequencer, MAC.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: tuser = func. A load (func 0) writes A, B and C0 at
//   (row, col); loads outside the n x n matrix are dropped.
//   A row request (func 1) streams row "row" of C on m_*, one transfer per
//   column 0..n-1, tlast on the final column; rows outside n give nothing.
//   cfg_wr_en / cfg_wr_data set n (0 reads as 1, capped at MAX_DIM and 64).
// Flow:
//   A row request holds s_tready low until the sequencer is back in idle,
//   so the next input transfer waits for the whole row: the single MAC unit
//   takes one A*B product per cycle while the output does not stall, behind
//   the store read, multiply and accumulate registers, and the results
//   follow one per column.
// Reset:
//   n returns to 64; the element stores are not cleared and must be loaded
//   before use.
// Backpressure:
//   While a result waits with m_tready low the whole MAC pipeline holds;
//   nothing is dropped.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate_core
    import mma_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [DIM_W-1:0]  cfg_wr_data,   // size_in_use
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [95:0]       s_tdata,       // row, col, a_value, b_value, c_init, zero pad
    input  logic              s_tuser,       // func
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [55:0]       m_tdata,       // result, out_col, zero pad
    output logic              m_tlast
);

    localparam logic [DIM_W-1:0] DIM_CAP = (MAX_DIM < 64) ? DIM_W'(MAX_DIM) : DIM_W'(64);

    logic [DIM_W-1:0]        size_reg, size_next;
    logic [DIM_W-1:0]        dim;
    logic [IDX_W-1:0]        in_row;
    logic [IDX_W-1:0]        in_col;
    logic signed [VAL_W-1:0] in_a;
    logic signed [VAL_W-1:0] in_b;
    logic signed [ACC_W-1:0] in_c;
    logic                    wr_en;
    logic [IDX_W-1:0]        rd_row;
    logic [IDX_W-1:0]        rd_k;
    logic [IDX_W-1:0]        rd_j;
    mma_tag_t                tag;
    logic                    stall;
    logic                    pipe_busy;
    logic signed [VAL_W-1:0] a_q;
    logic signed [VAL_W-1:0] b_q;
    logic signed [ACC_W-1:0] c_q;
    logic signed [ACC_W-1:0] m_result;
    logic [IDX_W-1:0]        m_col;

    assign size_next = cfg_wr_en ? cfg_wr_data : size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= DIM_W'(64);
        end else begin
            size_reg <= size_next;
        end
    end

    always_comb begin
        if (size_reg == '0) begin
            dim = DIM_W'(1);
        end else if (size_reg > DIM_CAP) begin
            dim = DIM_CAP;
        end else begin
            dim = size_reg;
        end
    end

    assign in_row = s_tdata[5:0];
    assign in_col = s_tdata[11:6];
    assign in_a   = s_tdata[27:12];
    assign in_b   = s_tdata[43:28];
    assign in_c   = s_tdata[91:44];

    mma_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_func   (s_tuser),
        .in_row    (in_row),
        .in_col    (in_col),
        .dim       (dim),
        .stall     (stall),
        .pipe_busy (pipe_busy),
        .wr_en     (wr_en),
        .rd_row    (rd_row),
        .rd_k      (rd_k),
        .rd_j      (rd_j),
        .tag_out   (tag)
    );

    mma_store #(
        .MAX_DIM (MAX_DIM)
    ) u_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_row (in_row),
        .wr_col (in_col),
        .wr_a   (in_a),
        .wr_b   (in_b),
        .wr_c   (in_c),
        .rd_en  (~stall),
        .rd_row (rd_row),
        .rd_k   (rd_k),
        .rd_j   (rd_j),
        .a_q    (a_q),
        .b_q    (b_q),
        .c_q    (c_q)
    );

    mma_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tag_in    (tag),
        .a_q       (a_q),
        .b_q       (b_q),
        .c_q       (c_q),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_result  (m_result),
        .m_col     (m_col),
        .m_last    (m_tlast),
        .stall     (stall),
        .pipe_busy (pipe_busy)
    );

    assign m_tdata = {2'b00, m_col, m_result};

endmodule

[dv/matrix_multiply_accumulate_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_checker: C row predictor and result checker
// Watches the size register, the input and the result stream, keeps its own
// copy of A, B and C0, works out every requested row of C = C0 + A*B with
// saturation after each addition, and compares each result transfer in order.
// ----------------------------------------------------------------------------
package mma_tb_pkg;

    typedef enum logic {
        FUNC_LOAD = 1'b0,
        FUNC_ROW  = 1'b1
    } mma_func_t;

endpackage

module matrix_multiply_accumulate_checker
    import mma_pkg::*;
    import mma_tb_pkg::*;
#(
    parameter int MAX_DIM = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [DIM_W-1:0]  cfg_wr_data,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [95:0]       s_tdata,       // row, col, a_value, b_value, c_init, zero pad
    input  logic              s_tuser,       // func
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [55:0]       m_tdata,       // result, out_col, zero pad
    input  logic              m_tlast,
    output int                mismatch_count,
    output int                due_count,
    output int                elems_checked
);

    localparam int STRIDE = 64;
    localparam longint ACC_MAX = longint'(SAT_HI);
    localparam longint ACC_MIN = longint'(SAT_LO);

    typedef struct {
        logic [ACC_W-1:0] value;
        logic [IDX_W-1:0] col;
        logic             last;
    } c_elem_t;

    logic signed [VAL_W-1:0] mat_a  [0:STRIDE*STRIDE-1];
    logic signed [VAL_W-1:0] mat_b  [0:STRIDE*STRIDE-1];
    logic signed [ACC_W-1:0] mat_c0 [0:STRIDE*STRIDE-1];
    logic [DIM_W-1:0]        size_reg = 7'd64;
    c_elem_t                 c_row_due [$];
    int                      err_total = 0;
    int                      elems_total = 0;

    always @(posedge aclk) begin : watch
        int unsigned n, r, c, j, k;
        longint      acc;
        c_elem_t     got, want;
        if (!aresetn) begin
            size_reg = 7'd64;
            c_row_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.value = m_tdata[ACC_W-1:0];
                got.col   = m_tdata[ACC_W +: IDX_W];
                got.last  = m_tlast;
                elems_total++;
                if (c_row_due.size() == 0) begin
                    $error("unexpected result transfer: out_col %0d, result %0d",
                           got.col, $signed(got.value));
                    err_total++;
                end else begin
                    want = c_row_due.pop_front();
                    if (got.value !== want.value) begin
                        $error("result: expected %0d, got %0d",
                               $signed(want.value), $signed(got.value));
                        err_total++;
                    end
                    if (got.col !== want.col) begin
                        $error("out_col: expected %0d, got %0d", want.col, got.col);
                        err_total++;
                    end
                    if (got.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, got.last);
                        err_total++;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                n = (size_reg == 0) ? 1 : size_reg;
                if (n > MAX_DIM) n = MAX_DIM;
                if (n > STRIDE) n = STRIDE;
                r = s_tdata[IDX_W-1:0];
                c = s_tdata[IDX_W +: IDX_W];
                if (r < n) begin
                    if (s_tuser == FUNC_LOAD) begin
                        // drop loads outside the n x n matrix
                        if (c < n) begin
                            mat_a[r*STRIDE + c]  = s_tdata[2*IDX_W +: VAL_W];
                            mat_b[r*STRIDE + c]  = s_tdata[2*IDX_W + VAL_W +: VAL_W];
                            mat_c0[r*STRIDE + c] = s_tdata[2*IDX_W + 2*VAL_W +: ACC_W];
                        end
                    end else begin
                        for (j = 0; j < n; j++) begin
                            acc = longint'(mat_c0[r*STRIDE + j]);
                            // saturate after every addition, k ascending
                            for (k = 0; k < n; k++) begin
                                acc += longint'(mat_a[r*STRIDE + k]) *
                                       longint'(mat_b[k*STRIDE + j]);
                                if (acc > ACC_MAX) acc = ACC_MAX;
                                if (acc < ACC_MIN) acc = ACC_MIN;
                            end
                            want.value = acc[ACC_W-1:0];
                            want.col   = j[IDX_W-1:0];
                            want.last  = (j + 1 == n);
                            c_row_due.push_back(want);
                        end
                    end
                end
            end

            if (cfg_wr_en) size_reg = cfg_wr_data;
        end
        mismatch_count <= err_total;
        due_count      <= c_row_due.size();
        elems_checked  <= elems_total;
    end

endmodule

[dv/matrix_multiply_accumulate_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_core_test: stimulus and verdict for the MAC core
// Loads the top-left 4 x 4 block of A, B and C0 at the reset size, runs
// directed rows for size limits and saturation, then random loads and row
// requests at small sizes under several mixes of sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module matrix_multiply_accumulate_core_test
    import mma_pkg::*;
    import mma_tb_pkg::*;
();

    localparam int MAX_DIM = 64;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [DIM_W-1:0]  cfg_wr_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [95:0]       s_tdata = '0;     // row, col, a_value, b_value, c_init, zero pad
    logic              s_tuser = 1'b0;   // func
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [55:0]       m_tdata;          // result, out_col, zero pad
    logic              m_tlast;

    int          mismatch_count;
    int          due_count;
    int          elems_checked;
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned dim_now = 64;
    int unsigned items_sent = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    matrix_multiply_accumulate_core #(
        .MAX_DIM (MAX_DIM)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    matrix_multiply_accumulate_checker #(
        .MAX_DIM (MAX_DIM)
    ) row_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .due_count      (due_count),
        .elems_checked  (elems_checked)
    );

    initial begin
        #10_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic logic [VAL_W-1:0] rand_q14();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [ACC_W-1:0] rand_c0();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return SAT_HI;
            1: return SAT_LO;
            2: return SAT_HI - bits[31:0];
            3: return SAT_LO + bits[31:0];
            4: return {{16{bits[31]}}, bits[31:0]};
            default: return bits[ACC_W-1:0];
        endcase
    endfunction

    task automatic set_idle(int unsigned gap, int unsigned stall);
        gap_pct   <= gap;
        stall_pct <= stall;
    endtask

    // Start in a clock step; return in the step where the transfer happened.
    task automatic send_item(mma_func_t func, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                             logic [VAL_W-1:0] a, logic [VAL_W-1:0] b,
                             logic [ACC_W-1:0] c0);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {4'b0, c0, b, a, col, row};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Wait out every expected result, then the longest row the core may still
    // be walking for a request that yields nothing.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_count != 0) @(posedge aclk);
        repeat (dim_now * dim_now + 8) @(posedge aclk);
    endtask

    task automatic set_size(logic [DIM_W-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        dim_now = (v == 0) ? 1 : (v > MAX_DIM) ? MAX_DIM : v;
    endtask

    initial begin : stimulus
        int unsigned r, c, ph;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset size is 64: load the top-left 4 x 4 block, the only part that
        // any later row reads, and one element at the far corner
        for (r = 0; r < 4; r++) begin
            for (c = 0; c < 4; c++) begin
                send_item(FUNC_LOAD, IDX_W'(r), IDX_W'(c),
                          rand_q14(), rand_q14(), rand_c0());
            end
        end
        send_item(FUNC_LOAD, 6'd63, 6'd63, rand_q14(), rand_q14(), rand_c0());

        // one by one: loads off the diagonal element must be dropped
        set_size(7'd1);
        send_item(FUNC_LOAD, 6'd0, 6'd0, 16'h7FFF, 16'h7FFF, '0);
        send_item(FUNC_ROW, 6'd0, 6'd0, '0, '0, '0);
        send_item(FUNC_LOAD, 6'd0, 6'd1, rand_q14(), rand_q14(), rand_c0());
        send_item(FUNC_LOAD, 6'd1, 6'd0, rand_q14(), rand_q14(), rand_c0());
        send_item(FUNC_ROW, 6'd1, 6'd0, rand_q14(), rand_q14(), rand_c0());
        send_item(FUNC_ROW, 6'd0, 6'd5, rand_q14(), rand_q14(), rand_c0());

        // zero size reads as one
        set_size(7'd0);
        send_item(FUNC_ROW, 6'd0, 6'd0, rand_q14(), rand_q14(), rand_c0());
        send_item(FUNC_ROW, 6'd1, 6'd0, rand_q14(), rand_q14(), rand_c0());

        // two by two: saturate high then fall back, saturate low then rise
        set_size(7'd2);
        set_idle(0, 48);
        send_item(FUNC_LOAD, 6'd0, 6'd0, 16'h8000, 16'h8000, SAT_HI - 5);
        send_item(FUNC_LOAD, 6'd0, 6'd1, 16'h0001, 16'h7FFF, SAT_LO + 3);
        send_item(FUNC_LOAD, 6'd1, 6'd0, rand_q14(), 16'h8000, rand_c0());
        send_item(FUNC_LOAD, 6'd1, 6'd1, rand_q14(), 16'h7FFF, rand_c0());
        send_item(FUNC_ROW, 6'd0, 6'd0, rand_q14(), rand_q14(), rand_c0());
        send_item(FUNC_ROW, 6'd1, 6'd0, rand_q14(), rand_q14(), rand_c0());
        send_item(FUNC_ROW, 6'd2, 6'd0, rand_q14(), rand_q14(), rand_c0());
        send_item(FUNC_LOAD, 6'd1, 6'd63, rand_q14(), rand_q14(), rand_c0());
        send_item(FUNC_LOAD, 6'd63, 6'd1, rand_q14(), rand_q14(), rand_c0());
        send_item(FUNC_ROW, 6'd1, 6'd0, rand_q14(), rand_q14(), rand_c0());

        // size above the maximum is capped
        set_size(7'd127);
        set_idle(0, 0);
        send_item(FUNC_LOAD, 6'd3, 6'd3, rand_q14(), rand_q14(), rand_c0());

        for (ph = 0; ph < 8; ph++) begin
            set_size(DIM_W'($urandom_range(1, 4)));
            case (ph % 4)
                0: set_idle(0, 0);
                1: set_idle(48, 0);
                2: set_idle(0, 48);
                default: set_idle(20, 20);
            endcase
            repeat (13) begin
                if ($urandom_range(0, 99) < 60) begin
                    r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                    : $urandom_range(0, dim_now - 1);
                    c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63)
                                                    : $urandom_range(0, dim_now - 1);
                    send_item(FUNC_LOAD, IDX_W'(r), IDX_W'(c),
                              rand_q14(), rand_q14(), rand_c0());
                end else begin
                    r = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63)
                                                    : $urandom_range(0, dim_now - 1);
                    send_item(FUNC_ROW, IDX_W'(r), IDX_W'($urandom_range(0, 63)),
                              rand_q14(), rand_q14(), rand_c0());
                end
            end
        end

        drain();
        $display("Sent %0d input transfers at sizes 0 to 4, 64 and 127 under four idle mixes;",
                 items_sent);
        $display("checked %0d result transfers including saturated sums.", elems_checked);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
